// ===== src/wsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsm_pkg;

   // Fixed field widths of the block's ports
   localparam int LEN_W    = 9;
   localparam int SMP_IN_W = 20;
   localparam int MEAN_W   = 44;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SETTLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic update;
      logic div_start;
      logic publish;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic no_window;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// ===== src/wsm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsm_div #(
   parameter int SUM_W     = 44,
   parameter int DEN_W     = 17,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [SUM_W-1:0]            num,
   input  wire logic [DEN_W-1:0]            den,
   output logic                             done,
   output logic [wsm_pkg::MEAN_W-1:0]       quot
);

   localparam int NUM_W  = SUM_W + FRAC_BITS;
   localparam int ITER_W = $clog2(NUM_W + 1);
   localparam int Q_W    = wsm_pkg::MEAN_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    quot_ff, quot_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   // One restoring step per cycle, numerator bits enter MSB first
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      iter_in = iter_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      priority if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         iter_in = ITER_W'(NUM_W);
         num_in  = NUM_W'(num) << FRAC_BITS;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {quot_ff[Q_W-2:0], fits};
         num_in  = num_ff << 1;
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== src/wsm_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsm_accum #(
   parameter int MAX_WINDOW  = 256,
   parameter int MAX_ITEMS   = 65536,
   parameter int SAMPLE_BITS = 20,
   localparam int SMP_W      = (SAMPLE_BITS < wsm_pkg::SMP_IN_W) ? SAMPLE_BITS
                                                                 : wsm_pkg::SMP_IN_W,
   localparam int KMAX       = (MAX_WINDOW < 511) ? MAX_WINDOW : 511,
   localparam int TOT_W      = SMP_W + $clog2(KMAX),
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1),
   localparam int SUM_W      = TOT_W + $clog2(MAX_ITEMS)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wsm_pkg::cmd_type                    cmd,
   input  wire logic                                csr_we,
   input  wire logic [wsm_pkg::LEN_W-1:0]           csr_window_len,
   input  wire logic [wsm_pkg::SMP_IN_W-1:0]        req_sample,
   output logic                                     no_window,
   output logic                                     overflow,
   output logic [SUM_W-1:0]                         sum,
   output logic [CNT_W-1:0]                         den
);

   localparam int LEN_W  = wsm_pkg::LEN_W;
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [SMP_W-1:0] ring_mem [MAX_WINDOW];
   logic [SMP_W-1:0] rd_ff;

   logic [LEN_W-1:0] window_len_ff, window_len_in;
   logic [LEN_W-1:0] active_len_ff, active_len_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             ovf_ff, ovf_in;
   logic             valid_ff, valid_in;
   logic             drop_ff, drop_in;
   logic             win_ff, win_in;
   logic             add_pend_ff, add_pend_in;
   logic [SMP_W-1:0] smp_ff, smp_in;

   logic [LEN_W-1:0] len_clamp;
   logic [LEN_W-1:0] k_now;
   logic             full;
   logic             store;
   logic [31:0]      back;
   logic [PTR_W-1:0] rd_idx;
   logic [PTR_W-1:0] wp_next;
   logic [SMP_W-1:0] smp;
   logic [TOT_W-1:0] leaving;

   assign smp = req_sample[SMP_W-1:0];

   always_comb begin
      priority if (window_len_ff == '0) begin
         len_clamp = LEN_W'(1);
      end else if (32'(window_len_ff) > 32'(MAX_WINDOW)) begin
         len_clamp = LEN_W'(MAX_WINDOW);
      end else begin
         len_clamp = window_len_ff;
      end
   end

   // Latch the window length on the first sample of a set
   assign k_now = (cnt_ff == '0) ? len_clamp : active_len_ff;
   assign full  = (cnt_ff == CNT_W'(MAX_ITEMS));
   assign store = cmd.take && !full;

   // Slot of the sample that leaves the window
   always_comb begin
      back = 32'(wp_ff) - 32'(k_now);
      if (32'(wp_ff) < 32'(k_now)) begin
         back = back + 32'(MAX_WINDOW);
      end
   end
   assign rd_idx = back[PTR_W-1:0];

   assign wp_next = (32'(wp_ff) == 32'(MAX_WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
   assign leaving = drop_ff ? TOT_W'(rd_ff) : '0;

   always_comb begin
      window_len_in = csr_we ? csr_window_len : window_len_ff;
      active_len_in = active_len_ff;
      wp_in         = wp_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      sum_in        = sum_ff;
      ovf_in        = ovf_ff;
      valid_in      = valid_ff;
      drop_in       = drop_ff;
      win_in        = win_ff;
      smp_in        = smp_ff;
      add_pend_in   = cmd.update && valid_ff && win_ff;
      if (add_pend_ff) begin
         sum_in = sum_ff + SUM_W'(total_ff);
      end
      if (cmd.take) begin
         active_len_in = k_now;
         valid_in      = !full;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            wp_in   = wp_next;
            cnt_in  = cnt_ff + CNT_W'(1);
            drop_in = 32'(cnt_ff) >= 32'(k_now);
            win_in  = (32'(cnt_ff) + 32'd1) >= 32'(k_now);
            smp_in  = smp;
         end
      end
      if (cmd.update && valid_ff) begin
         total_in = total_ff - leaving + TOT_W'(smp_ff);
      end
      if (cmd.clear) begin
         wp_in       = '0;
         cnt_in      = '0;
         total_in    = '0;
         sum_in      = '0;
         ovf_in      = 1'b0;
         add_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         ring_mem[wp_ff] <= smp;
      end
      rd_ff <= ring_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= LEN_W'(1);
         active_len_ff <= LEN_W'(1);
         wp_ff         <= '0;
         cnt_ff        <= '0;
         total_ff      <= '0;
         sum_ff        <= '0;
         ovf_ff        <= 1'b0;
         valid_ff      <= 1'b0;
         add_pend_ff   <= 1'b0;
      end else begin
         window_len_ff <= window_len_in;
         active_len_ff <= active_len_in;
         wp_ff         <= wp_in;
         cnt_ff        <= cnt_in;
         total_ff      <= total_in;
         sum_ff        <= sum_in;
         ovf_ff        <= ovf_in;
         valid_ff      <= valid_in;
         add_pend_ff   <= add_pend_in;
      end
      drop_ff <= drop_in;
      win_ff  <= win_in;
      smp_ff  <= smp_in;
   end

   assign no_window = 32'(cnt_ff) < 32'(active_len_ff);
   assign overflow  = ovf_ff;
   assign sum       = sum_ff;
   assign den       = cnt_ff - CNT_W'(active_len_ff) + CNT_W'(1);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(MAX_ITEMS))
      else $error("sample count above limit");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (cnt_ff == '0) && (sum_ff == '0) && !ovf_ff && !add_pend_ff)
      else $error("set state not cleared");

endmodule

`default_nettype wire

// ===== src/wsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last_sample,
   output logic                       req_stall,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   input  wire wsm_pkg::status_type   status,
   output wsm_pkg::cmd_type           cmd
);

   wsm_pkg::state_type state_ff, state_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = wsm_pkg::ST_UPDATE;
            end
         end
         wsm_pkg::ST_UPDATE: begin
            state_in = last_ff ? wsm_pkg::ST_SETTLE : wsm_pkg::ST_IDLE;
         end
         wsm_pkg::ST_SETTLE: begin
            state_in = wsm_pkg::ST_LOAD;
         end
         wsm_pkg::ST_LOAD: begin
            state_in = status.no_window ? wsm_pkg::ST_DONE : wsm_pkg::ST_DIVIDE;
         end
         wsm_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = wsm_pkg::ST_DONE;
            end
         end
         wsm_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = wsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_stall     = 1'b1;
      unique case (state_ff)
         wsm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         wsm_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         wsm_pkg::ST_SETTLE: begin
         end
         wsm_pkg::ST_LOAD: begin
            cmd.div_start = !status.no_window;
         end
         wsm_pkg::ST_DIVIDE: begin
         end
         wsm_pkg::ST_DONE: begin
            cmd.publish = out_free;
            cmd.clear   = out_free;
         end
         default: begin
         end
      endcase
   end

   assign last_in      = cmd.take ? req_last_sample : last_ff;
   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsm_pkg::ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_last_settles: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && req_last_sample) |=> ##1 (state_ff == wsm_pkg::ST_SETTLE))
      else $error("final request did not go on to settle");

endmodule

`default_nettype wire

// ===== src/window_sum_mean.sv =====
// A request with last_sample passes the update, settle, load and divide states before its
//   response is loaded; the divide is skipped when no window completed.
// Request flow: the request side stalls after each request for the window sum update, which
//   waits on the registered read of the sample ring; a final request holds the request side
//   through the bit-serial divide (one quotient bit a cycle) until its response is loaded.
// Reset (synchronous, active high): window length 1, empty set, no response; ring not cleared.
`timescale 1ns / 1ps
`default_nettype none

module window_sum_mean #(
   parameter int MAX_WINDOW  = 256,
   parameter int MAX_ITEMS   = 65536,
   parameter int SAMPLE_BITS = 20,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [wsm_pkg::SMP_IN_W-1:0]      req_sample,
   input  wire logic                              req_last_sample,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [wsm_pkg::MEAN_W-1:0]             rsp_mean_fixed,
   output logic                                   rsp_no_window,
   output logic                                   rsp_count_overflow,
   // window length register
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [wsm_pkg::LEN_W-1:0]         csr_window_len
);

   // Same width derivation as the accumulator
   localparam int SMP_W = (SAMPLE_BITS < wsm_pkg::SMP_IN_W) ? SAMPLE_BITS
                                                            : wsm_pkg::SMP_IN_W;
   localparam int KMAX  = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
   localparam int TOT_W = SMP_W + $clog2(KMAX);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = TOT_W + $clog2(MAX_ITEMS);

   wsm_pkg::cmd_type    cmd;
   wsm_pkg::status_type status;

   logic                        no_window;
   logic                        overflow;
   logic                        div_done;
   logic [SUM_W-1:0]            sum;
   logic [CNT_W-1:0]            den;
   logic [wsm_pkg::MEAN_W-1:0]  quot;

   logic [wsm_pkg::MEAN_W-1:0]  mean_ff, mean_in;
   logic                        no_win_ff, no_win_in;
   logic                        ovf_ff, ovf_in;

   // The register is always writable; a new length takes effect with the
   // first request of the next data set
   assign csr_ready = 1'b1;

   assign status = '{no_window: no_window, div_done: div_done};

   wsm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .status          (status),
      .cmd             (cmd)
   );

   // Sample ring, running window sum and total of window sums
   wsm_accum #(
      .MAX_WINDOW  (MAX_WINDOW),
      .MAX_ITEMS   (MAX_ITEMS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_valid && csr_ready),
      .csr_window_len (csr_window_len),
      .req_sample     (req_sample),
      .no_window      (no_window),
      .overflow       (overflow),
      .sum            (sum),
      .den            (den)
   );

   // Mean = total * 2^FRAC_BITS / (count - window + 1), truncated
   wsm_div #(
      .SUM_W     (SUM_W),
      .DEN_W     (CNT_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (sum),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   // Response register: load on publish, hold while the consumer stalls.
   // The set state clears in the same cycle, so the next request can enter
   // while this response still waits.
   always_comb begin
      mean_in   = mean_ff;
      no_win_in = no_win_ff;
      ovf_in    = ovf_ff;
      if (cmd.publish) begin
         mean_in   = no_window ? '0 : quot;
         no_win_in = no_window;
         ovf_in    = overflow;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff   <= mean_in;
      no_win_ff <= no_win_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_mean_fixed     = mean_ff;
   assign rsp_no_window      = no_win_ff;
   assign rsp_count_overflow = ovf_ff;

endmodule

`default_nettype wire
